/* design/rgbab_pkg.sv */
// Shared types and constants for the RGB565 alpha blend core.
// Used by every module of the block; no dependencies.
package rgbab_pkg;

    // Pixel channel masks and alpha limits
    localparam logic [15:0] MASK_R     = 16'hf800;
    localparam logic [15:0] MASK_G     = 16'h07e0;
    localparam logic [15:0] MASK_B     = 16'h001f;
    localparam logic [8:0]  ALPHA_ONE  = 9'h100;
    localparam logic [7:0]  ALPHA_FULL = 8'hff;
    localparam logic [7:0]  ALPHA_ZERO = 8'h00;

    // Configuration register indexes
    localparam int          CFG_IDX_W             = 2;
    localparam int          CFG_DATA_W            = 8;
    localparam logic [1:0]  CFG_ALPHA_FROM_REG    = 2'd0;
    localparam logic [1:0]  CFG_CONSTANT_ALPHA    = 2'd1;
    localparam logic [1:0]  CFG_BLACK_BOTTOM      = 2'd2;

    // Input beat
    typedef struct packed {
        logic [15:0] bottom_pixel;
        logic [15:0] top_pixel;
        logic [7:0]  pixel_alpha;
        logic        line_end;
    } pixel_in_t;

    // Result beat
    typedef struct packed {
        logic [15:0] blended_pixel;
        logic        line_end_out;
    } pixel_out_t;

    // Configuration state
    typedef struct packed {
        logic       alpha_from_register;
        logic [7:0] constant_alpha;
        logic       black_bottom;
    } cfg_t;

    // Operands of one pixel after alpha selection and bottom masking
    typedef struct packed {
        logic        valid;
        logic [15:0] bottom;
        logic [15:0] top;
        logic [7:0]  alpha;
        logic        line_end;
    } blend_op_t;

endpackage

/* design/rgbab_cfg_regs.sv */
// Configuration registers of the alpha blend core.
// Depends on rgbab_pkg.
module rgbab_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0]     wr_data,
    output rgbab_pkg::cfg_t                      cfg
);

    rgbab_pkg::cfg_t cfg_reg;
    rgbab_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                rgbab_pkg::CFG_ALPHA_FROM_REG: cfg_next.alpha_from_register = wr_data[0];
                rgbab_pkg::CFG_CONSTANT_ALPHA: cfg_next.constant_alpha      = wr_data;
                rgbab_pkg::CFG_BLACK_BOTTOM:   cfg_next.black_bottom        = wr_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_from_register <= 1'b0;
            cfg_reg.constant_alpha      <= rgbab_pkg::ALPHA_FULL;
            cfg_reg.black_bottom        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/rgbab_in_stage.sv */
// Input register of the alpha blend core: captures a beat, picks the alpha
// and masks the bottom pixel. Depends on rgbab_pkg.
module rgbab_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  rgbab_pkg::pixel_in_t  request,
    input  rgbab_pkg::cfg_t       cfg,
    output rgbab_pkg::blend_op_t  op
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [15:0]          bottom_reg;
    logic [15:0]          bottom_next;
    logic [15:0]          top_reg;
    logic [7:0]           alpha_reg;
    logic [7:0]           alpha_next;
    logic                 line_end_reg;

    // Select alpha source and force black bottom
    always_comb
    begin
        valid_next  = accept;
        alpha_next  = cfg.alpha_from_register ? cfg.constant_alpha : request.pixel_alpha;
        bottom_next = cfg.black_bottom ? 16'h0000 : request.bottom_pixel;
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold operands of the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bottom_reg   <= bottom_next;
            top_reg      <= request.top_pixel;
            alpha_reg    <= alpha_next;
            line_end_reg <= request.line_end;
        end
    end

    assign op.valid    = valid_reg;
    assign op.bottom   = bottom_reg;
    assign op.top      = top_reg;
    assign op.alpha    = alpha_reg;
    assign op.line_end = line_end_reg;

endmodule

/* design/rgbab_mix.sv */
// Blend datapath and result register of the alpha blend core.
// Depends on rgbab_pkg.
module rgbab_mix (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rgbab_pkg::blend_op_t  op,
    output logic                  done,
    output rgbab_pkg::pixel_out_t result
);

    logic [8:0]   ra;
    logic [7:0]   r_bot;
    logic [7:0]   g_bot;
    logic [7:0]   b_bot;
    logic [7:0]   r_top;
    logic [7:0]   g_top;
    logic [7:0]   b_top;
    logic [15:0]  r_sum;
    logic [15:0]  g_sum;
    logic [15:0]  b_sum;
    logic [15:0]  mixed;
    logic [15:0]  pixel_next;

    logic         done_reg;
    logic [15:0]  pixel_reg;
    logic         line_end_reg;

    // Widen channels to 8 bits and weight them; each weighted sum fits in 16 bits
    always_comb
    begin
        ra    = rgbab_pkg::ALPHA_ONE - {1'b0, op.alpha};
        r_bot = {op.bottom[15:11], 3'b000};
        g_bot = {op.bottom[10:5], 2'b00};
        b_bot = {op.bottom[4:0], 3'b000};
        r_top = {op.top[15:11], 3'b000};
        g_top = {op.top[10:5], 2'b00};
        b_top = {op.top[4:0], 3'b000};
        r_sum = {8'd0, r_bot} * {7'd0, ra} + {8'd0, r_top} * {8'd0, op.alpha};
        g_sum = {8'd0, g_bot} * {7'd0, ra} + {8'd0, g_top} * {8'd0, op.alpha};
        b_sum = {8'd0, b_bot} * {7'd0, ra} + {8'd0, b_top} * {8'd0, op.alpha};
        mixed = {r_sum[15:11], g_sum[15:10], b_sum[15:11]};
    end

    // Opaque and transparent pass straight through
    always_comb
    begin
        if (op.alpha == rgbab_pkg::ALPHA_FULL)
        begin
            pixel_next = op.top;
        end
        else if (op.alpha == rgbab_pkg::ALPHA_ZERO)
        begin
            pixel_next = op.bottom;
        end
        else
        begin
            pixel_next = mixed;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= op.valid;
        end
    end

    // Result beat
    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            pixel_reg    <= pixel_next;
            line_end_reg <= op.line_end;
        end
    end

    assign done                 = done_reg;
    assign result.blended_pixel = pixel_reg;
    assign result.line_end_out  = line_end_reg;

endmodule

/* design/rgb565_alpha_blend_core.sv */
// Top level of the RGB565 alpha blend core.
// Depends on rgbab_pkg, rgbab_cfg_regs, rgbab_in_stage and rgbab_mix.

// Blends a top RGB565 pixel over a bottom one with an 8-bit alpha, one pixel
// per clock. A beat is taken on any edge where start is high; busy is never
// raised. Each result appears on result for exactly one cycle with done high,
// after its beat has passed the input register and the result register, in
// input order; the receiver cannot stall, so it must take every done cycle.
// The channel multipliers sit between those two registers. Configuration
// writes (wr_en, wr_index, wr_data) take effect on the next edge and should
// only be made while no pixel is in flight.
module rgb565_alpha_blend_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rgbab_pkg::pixel_in_t                 request,
    output logic                                 done,
    output rgbab_pkg::pixel_out_t                result,
    input  logic                                 wr_en,
    input  logic [rgbab_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [rgbab_pkg::CFG_DATA_W-1:0]     wr_data
);

    rgbab_pkg::cfg_t       cfg;
    rgbab_pkg::blend_op_t  op;
    logic                  accept;

    // Always ready for the next beat
    assign busy   = 1'b0;
    assign accept = start && !busy;

    rgbab_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    rgbab_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .cfg     (cfg),
        .op      (op)
    );

    rgbab_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .done   (done),
        .result (result)
    );

endmodule

/* design/rgbab_checker.sv */
// Port-level checks for the RGB565 alpha blend core, bound to the top level.
// Depends on rgbab_pkg and rgb565_alpha_blend_core.
module rgbab_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  rgbab_pkg::pixel_in_t  request,
    input  logic                  done,
    input  rgbab_pkg::pixel_out_t result
);

    // Never refuse a beat
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every taken beat yields a result through the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing after beat");

    // No result without an earlier taken beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without beat");

    // Run marker travels with its pixel
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 (result.line_end_out == $past(request.line_end, 2)))
        else $error("line end marker mismatch");

endmodule

bind rgb565_alpha_blend_core rgbab_checker u_rgbab_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
